>>> hw/rtl/crpe_pkg.sv
// Shared types and constants for the Catmull-Rom path evaluator.
// Used by crpe_axis and catmull_rom_path_evaluator_unit; no dependencies.
package crpe_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam int COORD_W = 32;
    localparam int COUNT_W = 5;
    localparam int INDEX_W = 4;
    localparam int POS_W   = 17;
    localparam int SEG_W   = 6;
    localparam int SPROD_W = POS_W + COUNT_W;

    localparam logic [POS_W-1:0] ONE_Q16 = POS_W'(65536);

    // coefficient, accumulator and product widths of the Horner datapath
    localparam int COEF_W = 36;
    localparam int ACC_W  = 37;
    localparam int TS_W   = POS_W + 1;
    localparam int PROD_W = ACC_W + TS_W;
    localparam int FRAC_W = 16;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);
    localparam logic signed [ACC_W-1:0]  ACC_ONE  = ACC_W'(1);

    // register stages inside crpe_axis, and in front of it
    localparam int AXIS_LAT = 8;
    localparam int FRONT_LAT = 3;
    localparam int NSTG = FRONT_LAT + AXIS_LAT;

    localparam int RD_PORTS = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        logic               operation;
        logic [INDEX_W-1:0] point_index;
        t_coord             coord_x;
        t_coord             coord_y;
        t_coord             coord_z;
        logic [POS_W-1:0]   curve_position;
    } t_in_item;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        t_coord out_z;
    } t_out_item;

endpackage

>>> hw/rtl/crpe_axis.sv
// One axis of the cubic: coefficients, three Horner steps, rounding, saturation.
// Depends on crpe_pkg; advances on i_en.
module crpe_axis (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_zero,
    input  crpe_pkg::t_coord        i_p0,
    input  crpe_pkg::t_coord        i_p1,
    input  crpe_pkg::t_coord        i_p2,
    input  crpe_pkg::t_coord        i_p3,
    input  logic [crpe_pkg::POS_W-1:0] i_t,
    output crpe_pkg::t_coord        o_val
);
    import crpe_pkg::*;

    logic signed [COEF_W-1:0] w_e0, w_e1, w_e2, w_e3;
    logic signed [COEF_W-1:0] n_c0, n_c1, n_c2, n_c3;
    logic signed [COEF_W-1:0] r_c3, r_c2_d, r_c2_e;
    logic signed [COEF_W-1:0] r_c1 [4];
    logic signed [COEF_W-1:0] r_c0 [6];
    logic [POS_W-1:0]         r_t [5];

    logic signed [PROD_W-1:0] r_m1, r_m2, r_m3;
    logic signed [PROD_W-1:0] w_s1, w_s2, w_s3;
    logic signed [ACC_W-1:0]  r_a1, r_a2, r_a3;
    logic signed [ACC_W-1:0]  n_a1, n_a2, n_a3;
    logic signed [ACC_W-1:0]  w_half;
    logic signed [TS_W-1:0]   w_ts_e, w_ts_g, w_ts_i;
    t_coord                   n_out, r_out;

    always_comb begin
        w_e0 = COEF_W'(i_p0);
        w_e1 = COEF_W'(i_p1);
        w_e2 = COEF_W'(i_p2);
        w_e3 = COEF_W'(i_p3);
        n_c0 = w_e1 + w_e1;
        n_c1 = w_e2 - w_e0;
        n_c2 = (w_e0 <<< 1) - (w_e1 <<< 2) - w_e1 + (w_e2 <<< 2) - w_e3;
        n_c3 = (w_e1 <<< 1) + w_e1 - w_e0 - (w_e2 <<< 1) - w_e2 + w_e3;
        // empty path: all coefficients zero give a zero result
        if (i_zero) begin
            n_c0 = '0;
            n_c1 = '0;
            n_c2 = '0;
            n_c3 = '0;
        end
    end

    assign w_ts_e = $signed({1'b0, r_t[0]});
    assign w_ts_g = $signed({1'b0, r_t[2]});
    assign w_ts_i = $signed({1'b0, r_t[4]});

    // round to nearest, ties up: add half, then floor shift
    assign w_s1 = (r_m1 + RND_HALF) >>> FRAC_W;
    assign w_s2 = (r_m2 + RND_HALF) >>> FRAC_W;
    assign w_s3 = (r_m3 + RND_HALF) >>> FRAC_W;
    assign n_a1 = ACC_W'(w_s1) + ACC_W'(r_c2_e);
    assign n_a2 = ACC_W'(w_s2) + ACC_W'(r_c1[3]);
    assign n_a3 = ACC_W'(w_s3) + ACC_W'(r_c0[5]);

    always_comb begin
        w_half = (r_a3 + ACC_ONE) >>> 1;
        if (w_half[ACC_W-1:COORD_W-1] != {(ACC_W-COORD_W+1){w_half[ACC_W-1]}}) begin
            n_out = w_half[ACC_W-1] ? t_coord'({1'b1, {(COORD_W-1){1'b0}}})
                                    : t_coord'({1'b0, {(COORD_W-1){1'b1}}});
        end else begin
            n_out = w_half[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c3    <= n_c3;
            r_c2_d  <= n_c2;
            r_c2_e  <= r_c2_d;
            r_c1[0] <= n_c1;
            r_c0[0] <= n_c0;
            r_t[0]  <= i_t;
            for (int i = 1; i < 4; i++) r_c1[i] <= r_c1[i-1];
            for (int i = 1; i < 6; i++) r_c0[i] <= r_c0[i-1];
            for (int i = 1; i < 5; i++) r_t[i]  <= r_t[i-1];
            r_m1  <= ACC_W'(r_c3) * w_ts_e;
            r_a1  <= n_a1;
            r_m2  <= r_a1 * w_ts_g;
            r_a2  <= n_a2;
            r_m3  <= r_a2 * w_ts_i;
            r_a3  <= n_a3;
            r_out <= n_out;
        end
    end

    assign o_val = r_out;

endmodule

>>> hw/rtl/catmull_rom_path_evaluator_unit.sv
// Uniform Catmull-Rom path evaluator, top level.
// Depends on crpe_pkg and crpe_axis.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): a write beat stores a
//   control point in slot point_index; an evaluate beat samples the path at
//   curve_position (Q1.16, clamped to 1.0) and yields one output beat.
//   Output channel (o_out_valid / i_out_ready / o_out_data): x, y, z in Q16.16,
//   saturated. Write beats yield nothing.
//   i_cfg_we / i_cfg_wdata set point_count; change it only while idle.
//   Throughput: one beat per cycle while the receiver does not stall. A beat
//   passes from acceptance to o_out_valid through the 11-stage pipeline (index multiply, span clamp and
//   point fetch, then coefficients and three multiply/round Horner steps).
//   Point storage is four copies of a MAX_POINTS-entry memory, one read port
//   each, all written together; a point written by one beat is seen by the
//   next beat. Points are undefined until written.
//   Reset empties the pipeline and clears point_count; stored points are kept.
//   When the receiver stalls the whole pipeline holds and o_in_ready drops;
//   nothing is dropped or repeated.
module catmull_rom_path_evaluator_unit #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  crpe_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output crpe_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [crpe_pkg::COUNT_W-1:0]   i_cfg_wdata
);
    import crpe_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic                 w_en, w_acc;
    logic [NSTG-1:0]      r_vld;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   w_n;
    logic [POS_W-1:0]     w_ucl;

    logic [POS_W-1:0]     r_a_u;
    logic [COUNT_W-1:0]   r_a_n;
    logic [SPROD_W-1:0]   r_b_prod;
    logic [COUNT_W-1:0]   r_b_n;

    logic [SEG_W-1:0]     w_nm1, w_nm2, w_seg, w_i0, w_i1, w_i2, w_i3, w_s2;
    logic [SPROD_W-1:0]   w_diff;
    logic [POS_W-1:0]     w_t;
    logic [AW-1:0]        w_raddr [RD_PORTS];
    logic [AW-1:0]        w_waddr;
    logic                 w_wr;

    logic                 r_a_wr, r_b_wr;
    logic [AW-1:0]        r_a_waddr, r_b_waddr;
    t_point               r_a_wpt, r_b_wpt;

    t_point               r_mem [RD_PORTS][MAX_POINTS];
    t_point               r_p [RD_PORTS];
    logic [POS_W-1:0]     r_c_t;
    logic                 r_c_zero;

    t_coord               w_ox, w_oy, w_oz;

    assign w_en       = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_acc && (i_in_data.operation == OP_EVAL)};
        end
    end

    // entry: clamp count and position
    always_comb begin
        w_n   = (32'(r_count) > 32'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : r_count;
        w_ucl = (i_in_data.curve_position > ONE_Q16) ? ONE_Q16 : i_in_data.curve_position;
    end

    // point storage: a write travels with the pipeline and lands as it leaves
    // stage B, so it stays in order with the point fetch of evaluate beats
    assign w_waddr = AW'(i_in_data.point_index);
    assign w_wr    = w_acc && (i_in_data.operation == OP_WRITE)
                     && (32'(i_in_data.point_index) < 32'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_wr <= 1'b0;
            r_b_wr <= 1'b0;
        end else if (w_en) begin
            r_a_wr <= w_wr;
            r_b_wr <= r_a_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_waddr <= w_waddr;
            r_a_wpt   <= {i_in_data.coord_x, i_in_data.coord_y, i_in_data.coord_z};
            r_b_waddr <= r_a_waddr;
            r_b_wpt   <= r_a_wpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_b_wr) begin
            for (int k = 0; k < RD_PORTS; k++) begin
                r_mem[k][r_b_waddr] <= r_b_wpt;
            end
        end
    end

    // span clamp and neighbor indices, from stage B
    always_comb begin
        w_nm1 = SEG_W'(r_b_n) - SEG_W'(1);
        w_nm2 = SEG_W'(r_b_n) - SEG_W'(2);
        if (r_b_n < COUNT_W'(2)) begin
            w_seg = '0;
        end else if (r_b_prod[SPROD_W-1:FRAC_W] > w_nm2) begin
            w_seg = w_nm2;
        end else begin
            w_seg = r_b_prod[SPROD_W-1:FRAC_W];
        end
        w_diff = r_b_prod - {w_seg, {FRAC_W{1'b0}}};
        w_t    = (r_b_n < COUNT_W'(2)) ? '0 : w_diff[POS_W-1:0];
        w_s2   = w_seg + SEG_W'(2);
        w_i1   = w_seg;
        w_i0   = (w_seg == '0) ? '0 : w_seg - SEG_W'(1);
        if (r_b_n < COUNT_W'(2)) begin
            w_i2 = '0;
            w_i3 = '0;
        end else begin
            w_i2 = w_seg + SEG_W'(1);
            w_i3 = (w_s2 > w_nm1) ? w_nm1 : w_s2;
        end
        w_raddr[0] = AW'(w_i0);
        w_raddr[1] = AW'(w_i1);
        w_raddr[2] = AW'(w_i2);
        w_raddr[3] = AW'(w_i3);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_u    <= w_ucl;
            r_a_n    <= w_n;
            r_b_prod <= SPROD_W'(r_a_u) * SPROD_W'(r_a_n - COUNT_W'(1));
            r_b_n    <= r_a_n;
            r_c_t    <= w_t;
            r_c_zero <= (r_b_n == '0);
            for (int k = 0; k < RD_PORTS; k++) begin
                r_p[k] <= r_mem[k][w_raddr[k]];
            end
        end
    end

    crpe_axis u_axis_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_zero (r_c_zero),
        .i_p0   (r_p[0].x),
        .i_p1   (r_p[1].x),
        .i_p2   (r_p[2].x),
        .i_p3   (r_p[3].x),
        .i_t    (r_c_t),
        .o_val  (w_ox)
    );

    crpe_axis u_axis_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_zero (r_c_zero),
        .i_p0   (r_p[0].y),
        .i_p1   (r_p[1].y),
        .i_p2   (r_p[2].y),
        .i_p3   (r_p[3].y),
        .i_t    (r_c_t),
        .o_val  (w_oy)
    );

    crpe_axis u_axis_z (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_zero (r_c_zero),
        .i_p0   (r_p[0].z),
        .i_p1   (r_p[1].z),
        .i_p2   (r_p[2].z),
        .i_p3   (r_p[3].z),
        .i_t    (r_c_t),
        .o_val  (w_oz)
    );

    assign o_out_valid      = r_vld[NSTG-1];
    assign o_out_data.out_x = w_ox;
    assign o_out_data.out_y = w_oy;
    assign o_out_data.out_z = w_oz;

`ifndef SYNTHESIS
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_data.operation == OP_WRITE) |=> !r_vld[0])
        else $error("write beat entered the evaluate pipeline");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && (r_b_n >= COUNT_W'(2)) |-> (w_i3 < SEG_W'(r_b_n)) && (w_i2 <= w_i3))
        else $error("neighbor index outside the active points");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> w_t <= ONE_Q16)
        else $error("span fraction above 1.0");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output is stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

>>> verif/catmull_rom_path_evaluator_unit_tb.sv
// Self-checking testbench for catmull_rom_path_evaluator_unit: point writes, path evaluation,
// random bursts and output stalls, with a scoreboard that predicts each interpolated point.
// Depends on crpe_pkg and the evaluator RTL.
`timescale 1ns / 100ps

module catmull_rom_path_evaluator_unit_tb;
    import crpe_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     SETTLE      = NSTG + 4;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;
    localparam t_coord C_MAX       = 32'sh7FFFFFFF;
    localparam t_coord C_MIN       = 32'sh80000000;

    class spline_scoreboard;
        t_coord             pts [MAX_POINTS_DEF][3];
        logic [COUNT_W-1:0] count;
        t_out_item          pending_points[$];
        int                 failures;

        function new();
            count    = '0;
            failures = 0;
        endfunction

        static function longint rnd16(longint x);
            return (x + 64'sd32768) >>> 16;
        endfunction

        static function int clamp_idx(int i, int n);
            if (i < 0)
                return 0;
            if (i > n - 1)
                return n - 1;
            return i;
        endfunction

        // Horner evaluation of one axis, result saturated to Q16.16
        static function t_coord horner_axis(longint p0, longint p1, longint p2, longint p3,
                                            longint t);
            longint c0, c1, c2, c3, a;
            c0 = 2 * p1;
            c1 = p2 - p0;
            c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c3 = 3 * p1 - p0 - 3 * p2 + p3;
            a  = rnd16(c3 * t) + c2;
            a  = rnd16(a * t) + c1;
            a  = rnd16(a * t) + c0;
            a  = (a + 1) >>> 1;
            if (a > Q_MAX)
                a = Q_MAX;
            else if (a < Q_MIN)
                a = Q_MIN;
            return t_coord'(a);
        endfunction

        function t_out_item path_point(logic [POS_W-1:0] pos);
            t_out_item r;
            t_coord    res [3];
            int        n, s;
            int        idx [4];
            longint    u, prod, seg, t;
            n = (count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(count);
            if (n == 0)
                return '0;
            if (n == 1) begin
                r.out_x = pts[0][0];
                r.out_y = pts[0][1];
                r.out_z = pts[0][2];
                return r;
            end
            u = longint'(pos);
            if (u > 65536)
                u = 65536;
            prod = u * (n - 1);
            seg  = prod >>> 16;
            if (seg > n - 2)
                seg = n - 2;
            t = prod - (seg <<< 16);
            s = int'(seg);
            for (int k = 0; k < 4; k++)
                idx[k] = clamp_idx(s - 1 + k, n);
            for (int ax = 0; ax < 3; ax++)
                res[ax] = horner_axis(pts[idx[0]][ax], pts[idx[1]][ax], pts[idx[2]][ax],
                                      pts[idx[3]][ax], t);
            r.out_x = res[0];
            r.out_y = res[1];
            r.out_z = res[2];
            return r;
        endfunction

        function void note_beat(t_in_item it);
            if (it.operation == OP_WRITE) begin
                pts[it.point_index][0] = it.coord_x;
                pts[it.point_index][1] = it.coord_y;
                pts[it.point_index][2] = it.coord_z;
            end else begin
                pending_points = {pending_points, path_point(it.curve_position)};
            end
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;
            if (pending_points.size() == 0) begin
                if (failures < 10)
                    $display("ERROR: unexpected output beat x=%h y=%h z=%h",
                             got.out_x, got.out_y, got.out_z);
                failures++;
                return;
            end
            want = pending_points.pop_front();
            if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                got.out_z !== want.out_z) begin
                if (failures < 10)
                    $display("ERROR: mismatch exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                             want.out_x, want.out_y, want.out_z,
                             got.out_x, got.out_y, got.out_z);
                failures++;
            end
        endfunction

        function void flag_leftovers();
            if (pending_points.size() != 0) begin
                if (failures < 10)
                    $display("ERROR: %0d output beats never arrived", pending_points.size());
                failures += pending_points.size();
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_in_item           in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_item          out_data;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;

    spline_scoreboard   sb = new();
    int                 cycles = 0;

    // receiver stall pattern
    int                 stall_mode = 0;
    int                 stall_left = 0;
    logic [7:0]         stall_ctr  = '0;

    catmull_rom_path_evaluator_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        stall_ctr <= stall_ctr + 1'b1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= stall_ctr[2];
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(out_data);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [POS_W-1:0] pick_position(int n);
        int sel, k, off;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3, 4: return POS_W'($urandom_range(0, 65536));
            5: return POS_W'($urandom);
            6: return $urandom_range(0, 1) ? ONE_Q16 : '0;
            7: begin
                if (n < 2)
                    return POS_W'($urandom_range(0, 65536));
                // land on or next to a span boundary
                k   = $urandom_range(0, n - 1);
                off = $urandom_range(0, 2);
                return POS_W'((k * 65536) / (n - 1) + off - 1);
            end
            8: return POS_W'(65536 + $urandom_range(1, 65535));
            default: return POS_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_coord pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: return t_coord'($urandom);
            4: return C_MAX;
            5: return C_MIN;
            6: return $urandom_range(0, 1) ? t_coord'(0) : t_coord'(-1);
            default: return t_coord'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic t_in_item eval_beat(logic [POS_W-1:0] pos);
        t_in_item it;
        it.operation      = OP_EVAL;
        it.point_index    = INDEX_W'($urandom);
        it.coord_x        = t_coord'($urandom);
        it.coord_y        = t_coord'($urandom);
        it.coord_z        = t_coord'($urandom);
        it.curve_position = pos;
        return it;
    endfunction

    function automatic t_in_item write_beat(int slot, t_coord x, t_coord y, t_coord z);
        t_in_item it;
        it.operation      = OP_WRITE;
        it.point_index    = INDEX_W'(slot);
        it.coord_x        = x;
        it.coord_y        = y;
        it.coord_z        = z;
        it.curve_position = POS_W'($urandom);
        return it;
    endfunction

    // called right after a rising edge; returns at the edge that takes the beat
    task automatic send_beat(input t_in_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_beat(it);
    endtask

    task automatic hold_off(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_point_count(logic [COUNT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.count = v;
    endtask

    task automatic run_phase(int n_items, bit gaps, int n);
        int       sent, burst, gap;
        t_in_item it;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < n_items; b++) begin
                if ($urandom_range(0, 99) < 75)
                    it = eval_beat(pick_position(n));
                else
                    it = write_beat($urandom_range(0, 15), pick_coord(), pick_coord(),
                                    pick_coord());
                send_beat(it);
                sent++;
            end
            gap = (!gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
                hold_off(gap);
        end
    endtask

    initial begin
        int phase_counts [10];
        int n, n_items;
        t_coord x, y, z;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // count is zero out of reset: result is all zeros
        send_beat(eval_beat('0));
        send_beat(eval_beat('1));

        // load every slot, extremes included
        for (int k = 0; k < MAX_POINTS_DEF; k++) begin
            x = (k % 2 == 0) ? C_MAX : C_MIN;
            y = (k % 4 < 2) ? C_MIN : C_MAX;
            z = (k == 15) ? t_coord'(-1) : t_coord'((k - 8) * 65536);
            send_beat(write_beat(k, x, y, z));
        end
        wait_idle();

        set_point_count(COUNT_W'(1));
        send_beat(eval_beat(POS_W'(32768)));
        wait_idle();

        set_point_count(COUNT_W'(2));
        send_beat(eval_beat('0));
        send_beat(eval_beat(ONE_Q16));
        send_beat(eval_beat(POS_W'(32768)));
        wait_idle();

        set_point_count(COUNT_W'(MAX_POINTS_DEF));
        send_beat(eval_beat(ONE_Q16));
        send_beat(eval_beat('1));
        send_beat(eval_beat(POS_W'(65537)));
        send_beat(eval_beat(POS_W'(4369)));
        send_beat(eval_beat(POS_W'(1)));
        wait_idle();

        phase_counts = '{16, 2, 0, 16, 1, 3, 9, 16, 5, 16};
        phase_counts[6] = $urandom_range(2, 16);
        phase_counts[8] = $urandom_range(2, 16);
        for (int p = 0; p < 10; p++) begin
            n = phase_counts[p];
            set_point_count(COUNT_W'(n));
            n_items = (n < 2) ? 40 : 130;
            run_phase(n_items, p != 3, n);
            wait_idle();
        end

        sb.flag_leftovers();
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
